/* src/crpn_pkg.sv */
// ----------------------------------------------------------------------------
// crpn_pkg
// Shared types and codes of the complex integer postfix stack unit.
// ----------------------------------------------------------------------------
package crpn_pkg;

  localparam int unsigned DataW = 64;

  // Command codes carried in the input tuser field.
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;
  localparam logic [2:0] OP_SHOW = 3'd6;

  // Result status codes carried in the output tuser field.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_UNDER = 2'd1;
  localparam logic [1:0] STATUS_OVER  = 2'd2;

  // One stack entry; the real part sits in the low bits.
  typedef struct packed {
    logic [DataW-1:0] im;
    logic [DataW-1:0] re;
  } cplx_t;

endpackage

/* src/complex_rpn_stack_unit_core.sv */
// ----------------------------------------------------------------------------
// complex_rpn_stack_unit_core
// Postfix evaluator for 64-bit complex integers on a memory-based stack.
//
//   channel   | dir | tdata (low bit up)         | tuser
//   ----------+-----+----------------------------+--------------
//   s_axis    | in  | push_real, push_imag       | op
//   m_axis    | out | top_real, top_imag         | status
//
// Push writes the stack memory at acceptance. Add, subtract, negate and
// conjugate read the stack memory at acceptance and write it back in the next
// cycle. Show and error beats wait in S_RESP for the output register.
// Multiply passes twelve partial products through the single 32x32 multiplier.
// Reset empties the stack at once; the memory itself is not cleared. Input and
// output sides are parted by the output register, so a new beat is taken while
// a result is still waiting.
// ----------------------------------------------------------------------------
module complex_rpn_stack_unit_core
  import crpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // push_real, push_imag
  input  logic [2:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // top_real, top_imag
  output logic [1:0]   m_axis_tuser   // status
);

  localparam int unsigned AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EntryW = $bits(cplx_t);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [2:0]        op_q, op_d;
  logic [1:0]        status_q, status_d;
  logic              m_valid_q, m_valid_d;
  cplx_t             m_data_q, m_data_d;
  logic [1:0]        m_user_q, m_user_d;

  logic              accept;
  logic [CountW-1:0] top_idx;
  logic [CountW-1:0] sec_idx;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  cplx_t             mem_wdata;
  logic              mem_re;
  logic [EntryW-1:0] rd_top_raw;
  logic [EntryW-1:0] rd_sec_raw;
  cplx_t             rd_top;
  cplx_t             rd_sec;
  cplx_t             push_val;
  logic              mul_start;
  logic              mul_done;
  cplx_t             mul_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign top_idx       = count_q - CountW'(1);
  assign sec_idx       = count_q - CountW'(2);
  assign rd_top        = cplx_t'(rd_top_raw);
  assign rd_sec        = cplx_t'(rd_sec_raw);
  assign push_val.re   = s_axis_tdata[63:0];
  assign push_val.im   = s_axis_tdata[127:64];

  crpn_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AddrW),
    .DATA_W (EntryW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (EntryW'(mem_wdata)),
    .re_i      (mem_re),
    .raddr_a_i (top_idx[AddrW-1:0]),
    .raddr_b_i (sec_idx[AddrW-1:0]),
    .rdata_a_o (rd_top_raw),
    .rdata_b_o (rd_sec_raw)
  );

  // The read data stays put until the next accepted beat, so the multiplier
  // can use it directly as its operands.
  crpn_cmul u_cmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (rd_top),
    .b_i     (rd_sec),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    op_d      = op_q;
    status_d  = status_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    mem_waddr = top_idx[AddrW-1:0];
    mem_wdata = push_val;
    mem_re    = 1'b0;
    mul_start = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = s_axis_tuser;
          mem_re = (s_axis_tuser != OP_PUSH);
          case (s_axis_tuser)
            OP_PUSH: begin
              if (count_q == CountW'(STACK_DEPTH)) begin
                status_d = STATUS_OVER;
                state_d  = S_RESP;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AddrW-1:0];
                count_d   = count_q + CountW'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL: begin
              if (count_q < CountW'(2)) begin
                status_d = STATUS_UNDER;
                state_d  = S_RESP;
              end else begin
                state_d = (s_axis_tuser == OP_MUL) ? S_MSTART : S_EXEC;
              end
            end
            OP_NEG, OP_CONJ, OP_SHOW: begin
              if (count_q == '0) begin
                status_d = STATUS_UNDER;
                state_d  = S_RESP;
              end else if (s_axis_tuser == OP_SHOW) begin
                status_d = STATUS_OK;
                state_d  = S_RESP;
              end else begin
                state_d = S_EXEC;
              end
            end
            default: ;
          endcase
        end
      end

      S_EXEC: begin
        mem_we  = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_ADD: begin
            mem_waddr    = sec_idx[AddrW-1:0];
            mem_wdata.re = rd_sec.re + rd_top.re;
            mem_wdata.im = rd_sec.im + rd_top.im;
            count_d      = top_idx;
          end
          OP_SUB: begin
            mem_waddr    = sec_idx[AddrW-1:0];
            mem_wdata.re = rd_sec.re - rd_top.re;
            mem_wdata.im = rd_sec.im - rd_top.im;
            count_d      = top_idx;
          end
          OP_NEG: begin
            mem_wdata.re = '0 - rd_top.re;
            mem_wdata.im = '0 - rd_top.im;
          end
          default: begin
            // Conjugate flips only the imaginary part.
            mem_wdata.re = rd_top.re;
            mem_wdata.im = '0 - rd_top.im;
          end
        endcase
      end

      S_MSTART: begin
        mul_start = 1'b1;
        state_d   = S_MWAIT;
      end

      S_MWAIT: begin
        if (mul_done) begin
          mem_we    = 1'b1;
          mem_waddr = sec_idx[AddrW-1:0];
          mem_wdata = mul_res;
          count_d   = top_idx;
          state_d   = S_IDLE;
        end
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          m_data_d  = (status_q == STATUS_OK) ? rd_top : '0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_data_q.im, m_data_q.re};
  assign m_axis_tuser  = m_user_q;

endmodule

/* src/crpn_stack_mem.sv */
// ----------------------------------------------------------------------------
// crpn_stack_mem
// Stack storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module crpn_stack_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 128
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* src/crpn_cmul.sv */
// ----------------------------------------------------------------------------
// crpn_cmul
// Sequential complex multiplier built around one 32x32 multiplier.
// ----------------------------------------------------------------------------
module crpn_cmul
  import crpn_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  cplx_t a_i,     // top of stack, held stable while running
  input  cplx_t b_i,     // second from top, held stable while running
  output logic  done_o,
  output cplx_t res_o
);

  localparam int unsigned HalfW = DataW / 2;

  logic             run_q;
  logic [1:0]       prod_sel_q;
  logic [1:0]       part_sel_q;
  logic             pv_q;
  logic [1:0]       prod_tag_q;
  logic [1:0]       part_tag_q;
  logic             done_q;
  logic [DataW-1:0] prod_q;
  logic [DataW-1:0] acc_re_q;
  logic [DataW-1:0] acc_im_q;

  logic [DataW-1:0] op_x;
  logic [DataW-1:0] op_y;
  logic [HalfW-1:0] mul_x;
  logic [HalfW-1:0] mul_y;
  logic [DataW-1:0] prod_d;
  logic [DataW-1:0] term;

  // Four 64-bit products, each the wrapped sum of three 32-bit partials:
  // low*low, low*high and high*low, the latter two shifted up by 32.
  always_comb begin
    case (prod_sel_q)
      2'd0:    begin op_x = a_i.re; op_y = b_i.re; end
      2'd1:    begin op_x = a_i.im; op_y = b_i.im; end
      2'd2:    begin op_x = a_i.im; op_y = b_i.re; end
      default: begin op_x = b_i.im; op_y = a_i.re; end
    endcase
    case (part_sel_q)
      2'd1:    begin mul_x = op_x[HalfW-1:0]; mul_y = op_y[DataW-1:HalfW]; end
      2'd2:    begin mul_x = op_x[DataW-1:HalfW]; mul_y = op_y[HalfW-1:0]; end
      default: begin mul_x = op_x[HalfW-1:0]; mul_y = op_y[HalfW-1:0]; end
    endcase
    prod_d = DataW'(mul_x) * DataW'(mul_y);
    term   = (part_tag_q == 2'd0) ? prod_q : {prod_q[HalfW-1:0], {HalfW{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      prod_sel_q <= 2'd0;
      part_sel_q <= 2'd0;
      pv_q       <= 1'b0;
      prod_tag_q <= 2'd0;
      part_tag_q <= 2'd0;
      done_q     <= 1'b0;
    end else begin
      done_q <= pv_q && (prod_tag_q == 2'd3) && (part_tag_q == 2'd2);
      pv_q   <= run_q;
      if (start_i) begin
        run_q      <= 1'b1;
        prod_sel_q <= 2'd0;
        part_sel_q <= 2'd0;
      end else if (run_q) begin
        prod_tag_q <= prod_sel_q;
        part_tag_q <= part_sel_q;
        if (part_sel_q == 2'd2) begin
          part_sel_q <= 2'd0;
          if (prod_sel_q == 2'd3) begin
            run_q <= 1'b0;
          end else begin
            prod_sel_q <= prod_sel_q + 2'd1;
          end
        end else begin
          part_sel_q <= part_sel_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      prod_q <= prod_d;
    end
    if (start_i) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (pv_q) begin
      case (prod_tag_q)
        2'd0:    acc_re_q <= acc_re_q + term;
        2'd1:    acc_re_q <= acc_re_q - term;
        default: acc_im_q <= acc_im_q + term;
      endcase
    end
  end

  assign done_o   = done_q;
  assign res_o.re = acc_re_q;
  assign res_o.im = acc_im_q;

endmodule
